[hw/rtl/v3vu_pkg.sv]
// ----------------------------------------------------------------------------
// v3vu_pkg
// types, codes and saturation helpers for the three-component vector unit
// ----------------------------------------------------------------------------
package v3vu_pkg;

  localparam int W = 32;
  localparam int F = 16;

  typedef logic signed [W-1:0]   data_t;
  typedef logic [W-1:0]          umag_t;
  typedef logic signed [2*W-1:0] prod_t;
  typedef logic signed [71:0]    wide_t;

  localparam data_t MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam data_t MIN_V = {1'b1, {(W-1){1'b0}}};
  localparam data_t ONE_Q = data_t'(2**F);

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_SCALE    = 4'd2,
    OP_DIV      = 4'd3,
    OP_DOT      = 4'd4,
    OP_CROSS    = 4'd5,
    OP_HADAMARD = 4'd6,
    OP_LENSQ    = 4'd7,
    OP_LEN      = 4'd8,
    OP_UNIT     = 4'd9,
    OP_EQUAL    = 4'd10,
    OP_NEARZERO = 4'd11,
    OP_NEGATE   = 4'd12,
    OP_REFLECT  = 4'd13,
    OP_REFRACT  = 4'd14
  } opcode_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [3:0] opcode;
    data_t      a_x;
    data_t      a_y;
    data_t      a_z;
    data_t      b_x;
    data_t      b_y;
    data_t      b_z;
    data_t      scalar_in;
  } in_item_t;

  typedef struct packed {
    data_t      res_x;
    data_t      res_y;
    data_t      res_z;
    data_t      res_scalar;
    logic       res_flag;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic  ov;
    data_t val;
  } sat_t;

  function automatic sat_t sat_w(wide_t v);
    sat_t s;
    if (v > wide_t'(MAX_V)) begin
      s.ov  = 1'b1;
      s.val = MAX_V;
    end else if (v < wide_t'(MIN_V)) begin
      s.ov  = 1'b1;
      s.val = MIN_V;
    end else begin
      s.ov  = 1'b0;
      s.val = v[W-1:0];
    end
    return s;
  endfunction

  function automatic umag_t mag(data_t v);
    return v[W-1] ? umag_t'(-v) : umag_t'(v);
  endfunction

endpackage

[hw/rtl/vec3_vector_unit.sv]
// ----------------------------------------------------------------------------
// vec3_vector_unit
// pipelined signed fixed-point three-component vector alu
// ----------------------------------------------------------------------------
// One item is taken in every cycle that start is high; busy stays low since
// the pipeline never stalls. Every item gives one result on out_data, with
// out_valid high for one cycle, whatever its opcode. Every item passes through
// the 32-step square-root pipeline and the 48-step divider pipeline. The
// receiver cannot stall, so results must be taken as they come.
module vec3_vector_unit import v3vu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int NQ  = W + F;
  localparam int LAT = W + NQ + 11;
  localparam logic [2*W+1:0] TWO_ONE = (2*W+2)'(1) << (2*F);

  typedef struct packed {
    logic         vld;
    logic [3:0]   op;
    data_t [2:0]  a;
    data_t [2:0]  b;
    data_t        k;
    data_t [2:0]  r;
    data_t        sc;
    logic         flag;
    logic         ov;
    logic         dz;
    logic [2:0]   neg;
  } ctx_t;

  logic [15:0] nzl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nzl_r <= 16'd1;
    end else if (cfg_we) begin
      nzl_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // input register
  ctx_t s0_r, s0_nxt;

  always_comb begin
    s0_nxt      = '0;
    s0_nxt.vld  = start && !busy;
    s0_nxt.op   = in_data.opcode;
    s0_nxt.a    = {in_data.a_z, in_data.a_y, in_data.a_x};
    s0_nxt.b    = {in_data.b_z, in_data.b_y, in_data.b_x};
    s0_nxt.k    = in_data.scalar_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else begin
      s0_r <= s0_nxt;
    end
  end

  // stage 1: products and simple ops
  ctx_t        s1_r, s1_nxt;
  prod_t       s1_dot_r [3];
  prod_t       s1_cp_r [3];
  prod_t       s1_cn_r [3];
  prod_t       s1_ks_r [3];
  logic [2*W-1:0] s1_sq_r [3];
  sat_t        add_s [3];
  sat_t        sub_s [3];
  sat_t        neg_s [3];
  logic [2:0]  nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      add_s[i] = sat_w(wide_t'(s0_r.a[i]) + wide_t'(s0_r.b[i]));
      sub_s[i] = sat_w(wide_t'(s0_r.a[i]) - wide_t'(s0_r.b[i]));
      neg_s[i] = sat_w(-wide_t'(s0_r.a[i]));
      nz[i]    = mag(s0_r.a[i]) < umag_t'(nzl_r);
    end
    s1_nxt = s0_r;
    case (s0_r.op)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) s1_nxt.r[i] = add_s[i].val;
        s1_nxt.ov = add_s[0].ov | add_s[1].ov | add_s[2].ov;
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) s1_nxt.r[i] = sub_s[i].val;
        s1_nxt.ov = sub_s[0].ov | sub_s[1].ov | sub_s[2].ov;
      end
      OP_NEGATE: begin
        for (int i = 0; i < 3; i++) s1_nxt.r[i] = neg_s[i].val;
        s1_nxt.ov = neg_s[0].ov | neg_s[1].ov | neg_s[2].ov;
      end
      OP_EQUAL:    s1_nxt.flag = (s0_r.a == s0_r.b);
      OP_NEARZERO: s1_nxt.flag = &nz;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
    end
    for (int i = 0; i < 3; i++) begin
      s1_dot_r[i] <= s0_r.a[i] * s0_r.b[i];
      s1_cp_r[i]  <= s0_r.a[(i+1)%3] * s0_r.b[(i+2)%3];
      s1_cn_r[i]  <= s0_r.a[(i+2)%3] * s0_r.b[(i+1)%3];
      s1_ks_r[i]  <= s0_r.a[i] * s0_r.k;
      s1_sq_r[i]  <= mag(s0_r.a[i]) * mag(s0_r.a[i]);
    end
  end

  // stage 2: sums and rescaling
  ctx_t           s2_r, s2_nxt;
  data_t          s2_dc_r, s2_dc_nxt;
  logic [2*W-1:0] s2_rad_r;
  wide_t          dsum;
  sat_t           dpos_s, dneg_s;
  sat_t           crs_s [3];
  sat_t           had_s [3];
  sat_t           scl_s [3];
  logic [2*W+1:0] sqs, sqt;

  always_comb begin
    dsum   = wide_t'(s1_dot_r[0]) + wide_t'(s1_dot_r[1]) + wide_t'(s1_dot_r[2]);
    dpos_s = sat_w(dsum >>> F);
    dneg_s = sat_w((-dsum) >>> F);
    for (int i = 0; i < 3; i++) begin
      crs_s[i] = sat_w((wide_t'(s1_cp_r[i]) - wide_t'(s1_cn_r[i])) >>> F);
      had_s[i] = sat_w(wide_t'(s1_dot_r[i]) >>> F);
      scl_s[i] = sat_w(wide_t'(s1_ks_r[i]) >>> F);
    end
    sqs = (2*W+2)'(s1_sq_r[0]) + (2*W+2)'(s1_sq_r[1]) + (2*W+2)'(s1_sq_r[2]);
    sqt = sqs >> F;
    s2_nxt    = s1_r;
    s2_dc_nxt = dpos_s.val;
    case (s1_r.op)
      OP_DOT: begin
        s2_nxt.sc = dpos_s.val;
        s2_nxt.ov = dpos_s.ov;
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) s2_nxt.r[i] = crs_s[i].val;
        s2_nxt.ov = crs_s[0].ov | crs_s[1].ov | crs_s[2].ov;
      end
      OP_HADAMARD: begin
        for (int i = 0; i < 3; i++) s2_nxt.r[i] = had_s[i].val;
        s2_nxt.ov = had_s[0].ov | had_s[1].ov | had_s[2].ov;
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) s2_nxt.r[i] = scl_s[i].val;
        s2_nxt.ov = scl_s[0].ov | scl_s[1].ov | scl_s[2].ov;
      end
      OP_LENSQ: begin
        if (sqt > (2*W+2)'(MAX_V)) begin
          s2_nxt.sc = MAX_V;
          s2_nxt.ov = 1'b1;
        end else begin
          s2_nxt.sc = sqt[W-1:0];
        end
      end
      OP_REFLECT: s2_nxt.ov = dpos_s.ov;
      OP_REFRACT: begin
        s2_nxt.ov = dneg_s.ov;
        s2_dc_nxt = (dneg_s.val > ONE_Q) ? ONE_Q : dneg_s.val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else begin
      s2_r <= s2_nxt;
    end
    s2_dc_r  <= s2_dc_nxt;
    s2_rad_r <= sqs[2*W-1:0];
  end

  // stage 3: normal times dot or cosine
  ctx_t           s3_r;
  prod_t          s3_m_r [3];
  logic [2*W-1:0] s3_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else begin
      s3_r <= s2_r;
    end
    for (int i = 0; i < 3; i++) s3_m_r[i] <= s2_r.b[i] * s2_dc_r;
    s3_rad_r <= s2_rad_r;
  end

  // stage 4: reflect result, refract inner term
  ctx_t           s4_r, s4_nxt;
  logic [2*W-1:0] s4_rad_r;
  sat_t           rfl_s [3];
  sat_t           inr_s [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rfl_s[i] = sat_w(wide_t'(s3_r.a[i]) - (wide_t'(s3_m_r[i]) >>> (F-1)));
      inr_s[i] = sat_w(wide_t'(s3_r.a[i]) + (wide_t'(s3_m_r[i]) >>> F));
    end
    s4_nxt = s3_r;
    case (s3_r.op)
      OP_REFLECT: begin
        for (int i = 0; i < 3; i++) s4_nxt.r[i] = rfl_s[i].val;
        s4_nxt.ov = s3_r.ov | rfl_s[0].ov | rfl_s[1].ov | rfl_s[2].ov;
      end
      OP_REFRACT: begin
        for (int i = 0; i < 3; i++) s4_nxt.r[i] = inr_s[i].val;
        s4_nxt.ov = s3_r.ov | inr_s[0].ov | inr_s[1].ov | inr_s[2].ov;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.vld <= 1'b0;
    end else begin
      s4_r <= s4_nxt;
    end
    s4_rad_r <= s3_rad_r;
  end

  // stage 5: inner term times index ratio
  ctx_t           s5_r;
  prod_t          s5_m_r [3];
  logic [2*W-1:0] s5_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r.vld <= 1'b0;
    end else begin
      s5_r <= s4_r;
    end
    for (int i = 0; i < 3; i++) s5_m_r[i] <= s4_r.r[i] * s4_r.k;
    s5_rad_r <= s4_rad_r;
  end

  // stage 6: perpendicular part
  ctx_t           s6_r, s6_nxt;
  logic [2*W-1:0] s6_rad_r;
  sat_t           prp_s [3];

  always_comb begin
    for (int i = 0; i < 3; i++) prp_s[i] = sat_w(wide_t'(s5_m_r[i]) >>> F);
    s6_nxt = s5_r;
    if (s5_r.op == OP_REFRACT) begin
      for (int i = 0; i < 3; i++) s6_nxt.r[i] = prp_s[i].val;
      s6_nxt.ov = s5_r.ov | prp_s[0].ov | prp_s[1].ov | prp_s[2].ov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_r.vld <= 1'b0;
    end else begin
      s6_r <= s6_nxt;
    end
    s6_rad_r <= s5_rad_r;
  end

  // stage 7: squares of the perpendicular part
  ctx_t           s7_r;
  logic [2*W-1:0] s7_sq_r [3];
  logic [2*W-1:0] s7_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_r.vld <= 1'b0;
    end else begin
      s7_r <= s6_r;
    end
    for (int i = 0; i < 3; i++) s7_sq_r[i] <= mag(s6_r.r[i]) * mag(s6_r.r[i]);
    s7_rad_r <= s6_rad_r;
  end

  // stage 8 and square root: radicand select, then one root bit per stage
  ctx_t           sq_ctx_r [W+1];
  logic [2*W-1:0] sq_rem_r [W+1];
  logic [2*W-1:0] sq_res_r [W+1];
  logic [2*W+1:0] lsq, ldiff;

  always_comb begin
    lsq   = (2*W+2)'(s7_sq_r[0]) + (2*W+2)'(s7_sq_r[1]) + (2*W+2)'(s7_sq_r[2]);
    ldiff = (lsq >= TWO_ONE) ? lsq - TWO_ONE : TWO_ONE - lsq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctx_r[0].vld <= 1'b0;
    end else begin
      sq_ctx_r[0] <= s7_r;
    end
    sq_rem_r[0] <= (s7_r.op == OP_REFRACT) ? ldiff[2*W-1:0] : s7_rad_r;
    sq_res_r[0] <= '0;
  end

  for (genvar s = 0; s < W; s++) begin : g_sqrt
    localparam logic [2*W:0] BIT = (2*W+1)'(1) << (2*(W-1-s));
    logic [2*W:0] trial;

    assign trial = {1'b0, sq_res_r[s]} + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_ctx_r[s+1].vld <= 1'b0;
      end else begin
        sq_ctx_r[s+1] <= sq_ctx_r[s];
      end
      if ({1'b0, sq_rem_r[s]} >= trial) begin
        sq_rem_r[s+1] <= sq_rem_r[s] - trial[2*W-1:0];
        sq_res_r[s+1] <= (sq_res_r[s] >> 1) + BIT[2*W-1:0];
      end else begin
        sq_rem_r[s+1] <= sq_rem_r[s];
        sq_res_r[s+1] <= sq_res_r[s] >> 1;
      end
    end
  end

  // length, divider set-up and refract products
  ctx_t        dv_ctx_r [NQ+1];
  umag_t       dv_d_r [NQ+1];
  logic [W-1:0]  dv_rem_r [NQ+1][3];
  logic [NQ-1:0] dv_nq_r [NQ+1][3];
  prod_t       q1_pr_r [3];
  ctx_t        q1_nxt;
  umag_t       root;
  data_t       lens;
  logic        lens_ov;

  always_comb begin
    root    = sq_res_r[W][W-1:0];
    lens_ov = root[W-1];
    lens    = lens_ov ? MAX_V : data_t'(root);
    q1_nxt  = sq_ctx_r[W];
    for (int i = 0; i < 3; i++) begin
      q1_nxt.neg[i] = (sq_ctx_r[W].op == OP_DIV) ?
                      (sq_ctx_r[W].a[i][W-1] ^ sq_ctx_r[W].k[W-1]) :
                      sq_ctx_r[W].a[i][W-1];
    end
    case (sq_ctx_r[W].op)
      OP_LEN: begin
        q1_nxt.sc = lens;
        q1_nxt.ov = lens_ov;
      end
      OP_REFRACT: q1_nxt.ov = sq_ctx_r[W].ov | lens_ov;
      OP_UNIT:    q1_nxt.dz = (root == '0);
      OP_DIV:     q1_nxt.dz = (sq_ctx_r[W].k == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctx_r[0].vld <= 1'b0;
    end else begin
      dv_ctx_r[0] <= q1_nxt;
    end
    dv_d_r[0] <= (sq_ctx_r[W].op == OP_DIV) ? mag(sq_ctx_r[W].k) : root;
    for (int i = 0; i < 3; i++) begin
      q1_pr_r[i]     <= sq_ctx_r[W].b[i] * lens;
      dv_rem_r[0][i] <= '0;
      dv_nq_r[0][i]  <= {mag(sq_ctx_r[W].a[i]), {F{1'b0}}};
    end
  end

  // refract final sum, folded into the first divider stage
  ctx_t rf_ctx;
  sat_t par_s [3];
  sat_t fin_s [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      par_s[i] = sat_w((-wide_t'(q1_pr_r[i])) >>> F);
      fin_s[i] = sat_w(wide_t'(dv_ctx_r[0].r[i]) + wide_t'(par_s[i].val));
    end
    rf_ctx = dv_ctx_r[0];
    if (dv_ctx_r[0].op == OP_REFRACT) begin
      for (int i = 0; i < 3; i++) begin
        rf_ctx.r[i] = fin_s[i].val;
        rf_ctx.ov   = rf_ctx.ov | par_s[i].ov | fin_s[i].ov;
      end
    end
  end

  // restoring divider, one quotient bit per stage and lane
  for (genvar s = 0; s < NQ; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_ctx_r[s+1].vld <= 1'b0;
      end else begin
        dv_ctx_r[s+1] <= (s == 0) ? rf_ctx : dv_ctx_r[s];
      end
      dv_d_r[s+1] <= dv_d_r[s];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [W:0] shv, dif;
      logic       take;

      assign shv  = {dv_rem_r[s][l], dv_nq_r[s][l][NQ-1]};
      assign dif  = shv - {1'b0, dv_d_r[s]};
      assign take = shv >= {1'b0, dv_d_r[s]};

      always_ff @(posedge clk) begin
        dv_rem_r[s+1][l] <= take ? dif[W-1:0] : shv[W-1:0];
        dv_nq_r[s+1][l]  <= {dv_nq_r[s][l][NQ-2:0], take};
      end
    end
  end

  // output register
  ctx_t      oc;
  sat_t      quo_s [3];
  out_item_t out_nxt;
  out_item_t out_r;
  logic      out_vld_r;

  always_comb begin
    oc = dv_ctx_r[NQ];
    for (int i = 0; i < 3; i++) begin
      quo_s[i] = sat_w(oc.neg[i] ? -wide_t'(dv_nq_r[NQ][i]) : wide_t'(dv_nq_r[NQ][i]));
    end
    if ((oc.op == OP_DIV || oc.op == OP_UNIT) && !oc.dz) begin
      for (int i = 0; i < 3; i++) begin
        oc.r[i] = quo_s[i].val;
        oc.ov   = oc.ov | quo_s[i].ov;
      end
    end
    out_nxt.res_x      = oc.r[0];
    out_nxt.res_y      = oc.r[1];
    out_nxt.res_z      = oc.r[2];
    out_nxt.res_scalar = oc.sc;
    out_nxt.res_flag   = oc.flag;
    out_nxt.status     = oc.dz ? ST_DZ : (oc.ov ? ST_SAT : ST_OK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_ctx_r[NQ].vld;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an item taken in at the pipeline depth");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_DZ) |->
      (out_data.res_x == '0 && out_data.res_y == '0 && out_data.res_z == '0 &&
       out_data.res_scalar == '0 && !out_data.res_flag))
    else $error("divide by zero with non-zero result");

  a_flag_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.res_flag) |->
      (out_data.status == ST_OK && out_data.res_scalar == '0))
    else $error("flag result with scalar or bad status");

endmodule
